/* hdl/tri_pkg.sv */
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types, widths and constants of the three-anchor 2D position solver.
// ----------------------------------------------------------------------------
package tri_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 16;
  localparam int RANGE_W   = 16;
  localparam int TAG_W     = 8;
  localparam int POS_W     = 32;

  localparam int A_W   = 18;  // 2 * coordinate difference
  localparam int SQ_W  = 32;  // squared range
  localparam int C_W   = 33;  // anchor square-sum difference
  localparam int P_W   = 36;  // product of two matrix terms
  localparam int DET_W = 38;
  localparam int B_W   = 35;
  localparam int M_W   = 53;
  localparam int N_W   = 54;
  localparam int REM_W = 56;  // dividend 2|n| + |d|
  localparam int DEN_W = 38;  // divisor 2|d|
  localparam int CMP_W = 72;
  localparam int Q_W   = 32;

  // one overflow step plus one step per quotient bit
  localparam int DIV_STEPS = Q_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [TAG_W-1:0] TAG_ZERO_CODE = 8'h0f;

  localparam logic signed [COORD_W-1:0] RST_A0X = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_A0Y = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_A1X = -16'sd50;
  localparam logic signed [COORD_W-1:0] RST_A1Y = 16'sd365;
  localparam logic signed [COORD_W-1:0] RST_A2X = -16'sd434;
  localparam logic signed [COORD_W-1:0] RST_A2Y = 16'sd113;

  localparam logic [POS_W-1:0] POS_MAX = 32'h7fffffff;
  localparam logic [POS_W-1:0] POS_MIN = 32'h80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0X = 3'd0,
    REG_A0Y = 3'd1,
    REG_A1X = 3'd2,
    REG_A1Y = 3'd3,
    REG_A2X = 3'd4,
    REG_A2Y = 3'd5
  } tri_reg_e;

  // queued item: squared ranges and classified tag
  typedef struct packed {
    logic [SQ_W-1:0]  sq0;
    logic [SQ_W-1:0]  sq1;
    logic [SQ_W-1:0]  sq2;
    logic [TAG_W-1:0] tag_id;
  } tri_item_t;

  // terms derived from the anchor registers
  typedef struct packed {
    logic signed [A_W-1:0]   a00;
    logic signed [A_W-1:0]   a01;
    logic signed [A_W-1:0]   a10;
    logic signed [A_W-1:0]   a11;
    logic signed [C_W-1:0]   c0;
    logic signed [C_W-1:0]   c1;
    logic signed [DET_W-1:0] det;
  } tri_coef_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } tri_q_status_t;

endpackage

/* hdl/tri_ifs.sv */
// ----------------------------------------------------------------------------
// tri channel interfaces
// Ranging input, position result and configuration write channels.
// ----------------------------------------------------------------------------
interface tri_in_if;
  logic                         valid;
  logic                         ready;
  logic [tri_pkg::RANGE_W-1:0]  range_a0;
  logic [tri_pkg::RANGE_W-1:0]  range_a1;
  logic [tri_pkg::RANGE_W-1:0]  range_a2;
  logic [tri_pkg::TAG_W-1:0]    tag_code;
  modport source (output valid, range_a0, range_a1, range_a2, tag_code, input ready);
  modport sink   (input valid, range_a0, range_a1, range_a2, tag_code, output ready);
endinterface

interface tri_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tri_pkg::POS_W-1:0] pos_x;
  logic signed [tri_pkg::POS_W-1:0] pos_y;
  logic [tri_pkg::TAG_W-1:0]        tag_id;
  logic                             degenerate;
  modport source (output valid, pos_x, pos_y, tag_id, degenerate, input ready);
  modport sink   (input valid, pos_x, pos_y, tag_id, degenerate, output ready);
endinterface

interface tri_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tri_pkg::CFG_IDX_W-1:0] index;
  logic [tri_pkg::COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/tri_queue.sv */
// ----------------------------------------------------------------------------
// tri_queue
// Short FIFO between the front end and the solver pipeline.
// ----------------------------------------------------------------------------
module tri_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tri_pkg::tri_item_t     push_data,
  input  logic                   pop,
  output tri_pkg::tri_item_t     head,
  output tri_pkg::tri_q_status_t status
);

  tri_pkg::tri_item_t            mem [tri_pkg::QDEPTH];
  logic [tri_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tri_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tri_pkg::QCNT_W-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head         = mem[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == tri_pkg::QCNT_W'(tri_pkg::QDEPTH));

endmodule

/* hdl/tri_front.sv */
// ----------------------------------------------------------------------------
// tri_front
// Anchor registers and derived terms; accepts ranging items, squares the
// ranges, maps the tag code and hands the item to the queue.
// ----------------------------------------------------------------------------
module tri_front (
  input  logic                   clk,
  input  logic                   rst,
  tri_cfg_if.sink                cfg,
  tri_in_if.sink                 item,
  input  tri_pkg::tri_q_status_t q_status,
  output logic                   push,
  output tri_pkg::tri_item_t     push_data,
  output tri_pkg::tri_coef_t     coef
);

  logic signed [tri_pkg::COORD_W-1:0] x0, y0, x1, y1, x2, y2;

  // derived terms, refreshed every cycle
  logic signed [tri_pkg::A_W-1:0]   a00, a01, a10, a11;
  logic signed [tri_pkg::SQ_W-1:0]  sx0, sy0, sx1, sy1, sx2, sy2;
  logic signed [tri_pkg::C_W-1:0]   c0, c1;
  logic signed [tri_pkg::P_W-1:0]   pa, pb;
  logic signed [tri_pkg::DET_W-1:0] det;

  logic               f_valid;
  tri_pkg::tri_item_t f_item;
  logic               accept;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      x0 <= tri_pkg::RST_A0X;
      y0 <= tri_pkg::RST_A0Y;
      x1 <= tri_pkg::RST_A1X;
      y1 <= tri_pkg::RST_A1Y;
      x2 <= tri_pkg::RST_A2X;
      y2 <= tri_pkg::RST_A2Y;
    end else if (cfg.valid) begin
      case (tri_pkg::tri_reg_e'(cfg.index))
        tri_pkg::REG_A0X: x0 <= $signed(cfg.data);
        tri_pkg::REG_A0Y: y0 <= $signed(cfg.data);
        tri_pkg::REG_A1X: x1 <= $signed(cfg.data);
        tri_pkg::REG_A1Y: y1 <= $signed(cfg.data);
        tri_pkg::REG_A2X: x2 <= $signed(cfg.data);
        tri_pkg::REG_A2Y: y2 <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // three levels: differences and squares, sums and cross products, determinant
  always_ff @(posedge clk) begin
    a00 <= {17'(x0) - 17'(x2), 1'b0};
    a01 <= {17'(y0) - 17'(y2), 1'b0};
    a10 <= {17'(x1) - 17'(x2), 1'b0};
    a11 <= {17'(y1) - 17'(y2), 1'b0};
    sx0 <= x0 * x0;
    sy0 <= y0 * y0;
    sx1 <= x1 * x1;
    sy1 <= y1 * y1;
    sx2 <= x2 * x2;
    sy2 <= y2 * y2;
    c0  <= 33'(sx0) + 33'(sy0) - 33'(sx2) - 33'(sy2);
    c1  <= 33'(sx1) + 33'(sy1) - 33'(sx2) - 33'(sy2);
    pa  <= a00 * a11;
    pb  <= a01 * a10;
    det <= 38'(pa) - 38'(pb);
  end

  assign coef.a00 = a00;
  assign coef.a01 = a01;
  assign coef.a10 = a10;
  assign coef.a11 = a11;
  assign coef.c0  = c0;
  assign coef.c1  = c1;
  assign coef.det = det;

  assign push       = f_valid && !q_status.full;
  assign item.ready = !rst && (!f_valid || !q_status.full);
  assign accept     = item.valid && item.ready;
  assign push_data  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.sq0    <= 32'(item.range_a0) * 32'(item.range_a0);
      f_item.sq1    <= 32'(item.range_a1) * 32'(item.range_a1);
      f_item.sq2    <= 32'(item.range_a2) * 32'(item.range_a2);
      f_item.tag_id <= (item.tag_code == tri_pkg::TAG_ZERO_CODE) ? '0 : item.tag_code;
    end
  end

endmodule

/* hdl/tri_back.sv */
// ----------------------------------------------------------------------------
// tri_back
// Solver pipeline: right-hand side, products, numerators, magnitudes, a rounded
// dividend, a restoring divider with one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module tri_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tri_pkg::tri_coef_t     coef,
  input  tri_pkg::tri_item_t     head,
  input  tri_pkg::tri_q_status_t q_status,
  output logic                   pop,
  tri_out_if.source              result
);

  localparam int NS = tri_pkg::DIV_STEPS;

  logic en;

  logic v0, v1, v2, v3;
  logic [tri_pkg::TAG_W-1:0] t0, t1, t2, t3;

  logic signed [tri_pkg::B_W-1:0] b0, b1;
  logic signed [tri_pkg::M_W-1:0] m0, m1, m2, m3;
  logic signed [tri_pkg::N_W-1:0] nx, ny;
  logic [tri_pkg::N_W-1:0]        ax, ay;
  logic [tri_pkg::DEN_W-1:0]      dabs;
  logic                           s3_negx, s3_negy, s3_dz;

  // divider stage registers, index 0 holds the formed dividend and divisor
  logic                           dvld [NS+1];
  logic [tri_pkg::REM_W-1:0]      rx   [NS+1];
  logic [tri_pkg::REM_W-1:0]      ry   [NS+1];
  logic [tri_pkg::Q_W-1:0]        qx   [NS+1];
  logic [tri_pkg::Q_W-1:0]        qy   [NS+1];
  logic                           ovx  [NS+1];
  logic                           ovy  [NS+1];
  logic [tri_pkg::DEN_W-1:0]      dv   [NS+1];
  logic                           ngx  [NS+1];
  logic                           ngy  [NS+1];
  logic                           dz   [NS+1];
  logic [tri_pkg::TAG_W-1:0]      tg   [NS+1];

  logic                           gex  [NS];
  logic                           gey  [NS];
  logic [tri_pkg::REM_W-1:0]      subx [NS];
  logic [tri_pkg::REM_W-1:0]      suby [NS];

  logic                            out_valid;
  logic signed [tri_pkg::POS_W-1:0] out_x, out_y;
  logic [tri_pkg::TAG_W-1:0]       out_tag;
  logic                            out_dz;

  logic [tri_pkg::POS_W-1:0] fx, fy;

  assign en  = !out_valid || result.ready;
  assign pop = en && !q_status.empty;

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int j = 0; j <= NS; j++) begin
        dvld[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v0      <= !q_status.empty;
      v1      <= v0;
      v2      <= v1;
      v3      <= v2;
      dvld[0] <= v3;
      for (int j = 0; j < NS; j++) begin
        dvld[j+1] <= dvld[j];
      end
      out_valid <= dvld[NS];
    end
  end

  // B, products, numerators, magnitudes, dividend
  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= 35'($signed(coef.c0)) + $signed(35'(head.sq2)) - $signed(35'(head.sq0));
      b1 <= 35'($signed(coef.c1)) + $signed(35'(head.sq2)) - $signed(35'(head.sq1));
      t0 <= head.tag_id;

      m0 <= b0 * $signed(coef.a11);
      m1 <= b1 * $signed(coef.a01);
      m2 <= b1 * $signed(coef.a00);
      m3 <= b0 * $signed(coef.a10);
      t1 <= t0;

      nx <= 54'(m0) - 54'(m1);
      ny <= 54'(m2) - 54'(m3);
      t2 <= t1;

      ax      <= nx[tri_pkg::N_W-1] ? 54'(-nx) : 54'(nx);
      ay      <= ny[tri_pkg::N_W-1] ? 54'(-ny) : 54'(ny);
      dabs    <= coef.det[tri_pkg::DET_W-1] ? 38'(-coef.det) : 38'(coef.det);
      s3_negx <= nx[tri_pkg::N_W-1] ^ coef.det[tri_pkg::DET_W-1];
      s3_negy <= ny[tri_pkg::N_W-1] ^ coef.det[tri_pkg::DET_W-1];
      s3_dz   <= (coef.det == '0);
      t3      <= t2;

      // round to nearest: (2|n| + |d|) / (2|d|)
      rx[0]  <= tri_pkg::REM_W'({ax, 1'b0}) + tri_pkg::REM_W'(dabs);
      ry[0]  <= tri_pkg::REM_W'({ay, 1'b0}) + tri_pkg::REM_W'(dabs);
      dv[0]  <= tri_pkg::DEN_W'({dabs, 1'b0});
      qx[0]  <= '0;
      qy[0]  <= '0;
      ovx[0] <= 1'b0;
      ovy[0] <= 1'b0;
      ngx[0] <= s3_negx;
      ngy[0] <= s3_negy;
      dz[0]  <= s3_dz;
      tg[0]  <= t3;
    end
  end

  // first step only flags a quotient of 2^32 or more, the rest take one bit each
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      gex[j]  = tri_pkg::CMP_W'(rx[j]) >= (tri_pkg::CMP_W'(dv[j]) << (NS - 1 - j));
      gey[j]  = tri_pkg::CMP_W'(ry[j]) >= (tri_pkg::CMP_W'(dv[j]) << (NS - 1 - j));
      subx[j] = tri_pkg::REM_W'(tri_pkg::CMP_W'(rx[j])
                - (tri_pkg::CMP_W'(dv[j]) << (NS - 1 - j)));
      suby[j] = tri_pkg::REM_W'(tri_pkg::CMP_W'(ry[j])
                - (tri_pkg::CMP_W'(dv[j]) << (NS - 1 - j)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        if (j == 0) begin
          rx[j+1]  <= rx[j];
          ry[j+1]  <= ry[j];
          qx[j+1]  <= qx[j];
          qy[j+1]  <= qy[j];
          ovx[j+1] <= gex[j];
          ovy[j+1] <= gey[j];
        end else begin
          rx[j+1]  <= gex[j] ? subx[j] : rx[j];
          ry[j+1]  <= gey[j] ? suby[j] : ry[j];
          qx[j+1]  <= {qx[j][tri_pkg::Q_W-2:0], gex[j]};
          qy[j+1]  <= {qy[j][tri_pkg::Q_W-2:0], gey[j]};
          ovx[j+1] <= ovx[j];
          ovy[j+1] <= ovy[j];
        end
        dv[j+1]  <= dv[j];
        ngx[j+1] <= ngx[j];
        ngy[j+1] <= ngy[j];
        dz[j+1]  <= dz[j];
        tg[j+1]  <= tg[j];
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (ngx[NS]) begin
      fx = (ovx[NS] || (qx[NS][tri_pkg::Q_W-1] && (qx[NS][tri_pkg::Q_W-2:0] != '0)))
           ? tri_pkg::POS_MIN : ('0 - qx[NS]);
    end else begin
      fx = (ovx[NS] || qx[NS][tri_pkg::Q_W-1]) ? tri_pkg::POS_MAX : qx[NS];
    end
    if (ngy[NS]) begin
      fy = (ovy[NS] || (qy[NS][tri_pkg::Q_W-1] && (qy[NS][tri_pkg::Q_W-2:0] != '0)))
           ? tri_pkg::POS_MIN : ('0 - qy[NS]);
    end else begin
      fy = (ovy[NS] || qy[NS][tri_pkg::Q_W-1]) ? tri_pkg::POS_MAX : qy[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x   <= dz[NS] ? '0 : $signed(fx);
      out_y   <= dz[NS] ? '0 : $signed(fy);
      out_dz  <= dz[NS];
      out_tag <= tg[NS];
    end
  end

  assign result.valid      = out_valid;
  assign result.pos_x      = out_x;
  assign result.pos_y      = out_y;
  assign result.tag_id     = out_tag;
  assign result.degenerate = out_dz;

endmodule

/* hdl/trilateration_2d_three_anchor_unit.sv */
// ----------------------------------------------------------------------------
// trilateration_2d_three_anchor_unit
// Solves the tag x/y position from three anchor ranges.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  item     in   valid/ready   range_a0, range_a1, range_a2, tag_code
//  result   out  valid/ready   pos_x, pos_y, tag_id, degenerate
//  cfg      in   valid/ready   index, data (anchor coordinate)
//
//  One item per cycle sustained while the result is not stalled; a result
//  passes the front register, the queue, 5 arithmetic stages (rhs,
//  products, numerators, magnitudes, dividend), 33 divider stages and the
//  output stage.
//  The restoring divider (one quotient bit per stage) sets the depth.
//  Synchronous reset loads the default anchors and empties the pipeline.
//  A stalled result freezes the solver pipeline; the queue lets the front
//  keep taking items until it fills.
// ----------------------------------------------------------------------------
module trilateration_2d_three_anchor_unit (
  input  logic       clk,
  input  logic       rst,
  tri_in_if.sink     item,
  tri_out_if.source  result,
  tri_cfg_if.sink    cfg
);

  logic                   push;
  logic                   pop;
  tri_pkg::tri_item_t     push_data;
  tri_pkg::tri_item_t     head;
  tri_pkg::tri_coef_t     coef;
  tri_pkg::tri_q_status_t q_status;

  tri_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data),
    .coef      (coef)
  );

  tri_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tri_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .result   (result)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> result.pos_x == '0 && result.pos_y == '0)
    else $error("degenerate result with nonzero position");

  a_tag_mapped: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.tag_id != tri_pkg::TAG_ZERO_CODE)
    else $error("tag code 0x0f not mapped to zero");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push || pop)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule
